@@ rtl/core/gbn_pkg.sv @@
package gbn_pkg;

    localparam int SEQ_W     = 3;
    localparam int SEQ_SPACE = 8;
    localparam int STATUS_W  = 3;
    localparam int KIND_W    = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SEQ_W-1:0]      WIN_MAX      = SEQ_W'(SEQ_SPACE - 1);
    localparam logic [SEQ_W-1:0]      WINDOW_RESET = SEQ_W'(4);
    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW  = APB_ADDR_W'(0);

    typedef logic [SEQ_W-1:0] seq_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND    = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SENT        = 3'd0,
        ST_REFUSED     = 3'd1,
        ST_ACK_TAKEN   = 3'd2,
        ST_ACK_CORRUPT = 3'd3,
        ST_ACK_OUTSIDE = 3'd4,
        ST_RETX        = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SEND,
        OP_ACK,
        OP_TO_EMPTY,
        OP_TO_BEGIN,
        OP_READ,
        OP_RETX
    } op_t;

    typedef struct packed {
        logic in_ready;
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic  in_valid;
        kind_t kind;
        logic  window_empty;
        logic  out_free;
        logic  retx_last;
    } dp_stat_t;

    typedef struct packed {
        status_t status;
        logic    packet_valid;
        seq_t    packet_seq;
        logic    timer_stop;
        seq_t    timer_stop_seq;
        logic    timer_start;
        seq_t    timer_start_seq;
        logic    last;
        seq_t    window_count;
    } rsp_info_t;

endpackage

@@ rtl/core/gbn_item_if.sv @@
interface gbn_item_if
    import gbn_pkg::*;
#(
    parameter int PAYLOAD_BITS = 64
);
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_W-1:0]        ack_num;
    logic                    checksum_ok;
    logic [SEQ_W-1:0]        timeout_seq;

    modport source (
        output valid, kind, payload, ack_num, checksum_ok, timeout_seq,
        input  ready
    );

    modport sink (
        input  valid, kind, payload, ack_num, checksum_ok, timeout_seq,
        output ready
    );
endinterface

@@ rtl/core/gbn_result_if.sv @@
interface gbn_result_if
    import gbn_pkg::*;
#(
    parameter int PAYLOAD_BITS = 64
);
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic                    packet_valid;
    logic [SEQ_W-1:0]        packet_seq;
    logic [PAYLOAD_BITS-1:0] packet_payload;
    logic                    timer_stop;
    logic [SEQ_W-1:0]        timer_stop_seq;
    logic                    timer_start;
    logic [SEQ_W-1:0]        timer_start_seq;
    logic                    last;
    logic [SEQ_W-1:0]        window_count;

    modport source (
        output valid, status, packet_valid, packet_seq, packet_payload, timer_stop,
               timer_stop_seq, timer_start, timer_start_seq, last, window_count,
        input  ready
    );

    modport sink (
        input  valid, status, packet_valid, packet_seq, packet_payload, timer_stop,
               timer_stop_seq, timer_start, timer_start_seq, last, window_count,
        output ready
    );
endinterface

@@ rtl/core/gbn_ctrl.sv @@
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.in_valid && stat.out_free && stat.kind == KIND_TIMEOUT
                    && !stat.window_empty)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.retx_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.in_ready = 1'b0;
        cmd.op       = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = stat.out_free;
                if (stat.in_valid && stat.out_free)
                begin
                    case (stat.kind)
                        KIND_SEND:    cmd.op = OP_SEND;
                        KIND_ACK:     cmd.op = OP_ACK;
                        KIND_TIMEOUT: cmd.op = stat.window_empty ? OP_TO_EMPTY : OP_TO_BEGIN;
                        default:      cmd.op = OP_NONE;
                    endcase
                end
            end
            S_READ:
            begin
                cmd.op = OP_READ;
            end
            S_EMIT:
            begin
                cmd.op = stat.out_free ? OP_RETX : OP_NONE;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    // A read is always followed by the load of the data it fetched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_READ) |=> (state_reg == S_EMIT))
        else $error("read not followed by emit state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd.in_ready)
        else $error("input taken during retransmission");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_TO_BEGIN) |=> (state_reg == S_READ))
        else $error("retransmission did not start");

endmodule

@@ rtl/core/gbn_dp.sv @@
module gbn_dp
    import gbn_pkg::*;
#(
    parameter int PAYLOAD_BITS = 64
)(
    input  logic        clk,
    input  logic        rst_n,
    input  seq_t        window_len,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    gbn_item_if.sink    item,
    gbn_result_if.source result
);

    seq_t base_seq_reg, base_seq_next;
    seq_t next_seq_reg, next_seq_next;
    seq_t outstanding_reg, outstanding_next;
    seq_t cnt_reg, cnt_next;
    seq_t tseq_reg, tseq_next;
    logic out_valid_reg;
    rsp_info_t info_reg, info_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [PAYLOAD_BITS-1:0] rdata_reg;
    logic [PAYLOAD_BITS-1:0] store [SEQ_SPACE];

    seq_t win_eff;
    seq_t ack_off;
    seq_t rd_addr;
    logic out_free;
    logic retx_last;
    logic full;
    logic mem_we;
    logic load;

    assign win_eff   = (window_len > WIN_MAX) ? WIN_MAX : window_len;
    assign full      = (outstanding_reg >= win_eff);
    assign ack_off   = item.ack_num - base_seq_reg;
    assign rd_addr   = base_seq_reg + cnt_reg;
    assign retx_last = (cnt_reg + SEQ_W'(1)) == outstanding_reg;
    assign out_free  = !out_valid_reg || result.ready;
    assign mem_we    = (cmd.op == OP_SEND) && !full;
    assign load      = (cmd.op == OP_SEND) || (cmd.op == OP_ACK) ||
                       (cmd.op == OP_TO_EMPTY) || (cmd.op == OP_RETX);

    assign stat.in_valid     = item.valid;
    assign stat.kind         = kind_t'(item.kind);
    assign stat.window_empty = (outstanding_reg == '0);
    assign stat.out_free     = out_free;
    assign stat.retx_last    = retx_last;

    assign item.ready = cmd.in_ready;

    always_comb
    begin
        base_seq_next    = base_seq_reg;
        next_seq_next    = next_seq_reg;
        outstanding_next = outstanding_reg;
        cnt_next         = cnt_reg;
        tseq_next        = tseq_reg;
        info_next        = info_reg;
        pay_next         = pay_reg;
        if (load)
        begin
            info_next = '0;
            pay_next  = '0;
        end
        case (cmd.op)
            OP_SEND:
            begin
                if (full)
                begin
                    info_next.status = ST_REFUSED;
                end
                else
                begin
                    next_seq_next             = next_seq_reg + SEQ_W'(1);
                    outstanding_next          = outstanding_reg + SEQ_W'(1);
                    info_next.status          = ST_SENT;
                    info_next.packet_valid    = 1'b1;
                    info_next.packet_seq      = next_seq_reg;
                    pay_next                  = item.payload;
                    info_next.timer_start     = (outstanding_reg == '0);
                    info_next.timer_start_seq = (outstanding_reg == '0) ? next_seq_reg : '0;
                end
            end
            OP_ACK:
            begin
                if (!item.checksum_ok)
                begin
                    info_next.status = ST_ACK_CORRUPT;
                end
                else if (ack_off >= outstanding_reg)
                begin
                    info_next.status = ST_ACK_OUTSIDE;
                end
                else
                begin
                    base_seq_next            = item.ack_num + SEQ_W'(1);
                    outstanding_next         = outstanding_reg - ack_off - SEQ_W'(1);
                    info_next.status         = ST_ACK_TAKEN;
                    info_next.timer_stop     = 1'b1;
                    info_next.timer_stop_seq = base_seq_reg;
                    info_next.timer_start    = (outstanding_next != '0);
                    info_next.timer_start_seq =
                        (outstanding_next != '0) ? base_seq_next : '0;
                end
            end
            OP_TO_EMPTY:
            begin
                info_next.status          = ST_RETX;
                info_next.timer_stop      = 1'b1;
                info_next.timer_stop_seq  = item.timeout_seq;
                info_next.timer_start     = 1'b1;
                info_next.timer_start_seq = item.timeout_seq;
            end
            OP_TO_BEGIN:
            begin
                tseq_next = item.timeout_seq;
                cnt_next  = '0;
            end
            OP_RETX:
            begin
                info_next.status          = ST_RETX;
                info_next.packet_valid    = 1'b1;
                info_next.packet_seq      = rd_addr;
                pay_next                  = rdata_reg;
                info_next.timer_stop      = (cnt_reg == '0);
                info_next.timer_stop_seq  = (cnt_reg == '0) ? tseq_reg : '0;
                info_next.timer_start     = (cnt_reg == '0);
                info_next.timer_start_seq = (cnt_reg == '0) ? tseq_reg : '0;
                cnt_next                  = cnt_reg + SEQ_W'(1);
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            info_next.last         = (cmd.op == OP_RETX) ? retx_last : 1'b1;
            info_next.window_count = outstanding_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_seq_reg    <= '0;
            next_seq_reg    <= '0;
            outstanding_reg <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            base_seq_reg    <= base_seq_next;
            next_seq_reg    <= next_seq_next;
            outstanding_reg <= outstanding_next;
            cnt_reg         <= cnt_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tseq_reg <= tseq_next;
        info_reg <= info_next;
        pay_reg  <= pay_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[next_seq_reg] <= item.payload;
        end
        if (cmd.op == OP_READ)
        begin
            rdata_reg <= store[rd_addr];
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.status          = info_reg.status;
    assign result.packet_valid    = info_reg.packet_valid;
    assign result.packet_seq      = info_reg.packet_seq;
    assign result.packet_payload  = pay_reg;
    assign result.timer_stop      = info_reg.timer_stop;
    assign result.timer_stop_seq  = info_reg.timer_stop_seq;
    assign result.timer_start     = info_reg.timer_start;
    assign result.timer_start_seq = info_reg.timer_start_seq;
    assign result.last            = info_reg.last;
    assign result.window_count    = info_reg.window_count;

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (outstanding_reg == $past(outstanding_reg) + SEQ_W'(1)))
        else $error("accepted send did not grow the window");

    // The last retransmitted packet is the newest one in the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RETX && retx_last) |-> (rd_addr + SEQ_W'(1) == next_seq_reg))
        else $error("retransmission ended away from the window edge");

    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("result overwritten before transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (outstanding_reg == '0) |-> (base_seq_reg == next_seq_reg))
        else $error("empty window with base and next apart");

endmodule

@@ rtl/core/go_back_n_sender_unit.sv @@
// Sends, acknowledgements and timeouts with an empty window give one result, registered at
// the transfer edge and shown from the next cycle; one such item is taken per cycle unless
// the result is stalled. A timeout with N packets outstanding gives N results, each a packet
// store read then the output load, and no new item is taken until the last one is loaded.
// Reset clears the window, both sequence numbers and sets window_len to 4.
// The packet store is not cleared by reset.
module go_back_n_sender_unit
    import gbn_pkg::*;
#(
    parameter int PAYLOAD_BITS = 64
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    gbn_item_if.sink              item,
    gbn_result_if.source          result
);

    seq_t      window_len_reg;
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WINDOW) ? APB_DATA_W'(window_len_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_WINDOW)
        begin
            window_len_reg <= pwdata[SEQ_W-1:0];
        end
    end

    gbn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    gbn_dp #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .window_len (window_len_reg),
        .cmd        (cmd),
        .stat       (stat),
        .item       (item),
        .result     (result)
    );

endmodule
